// File: rtl/rsh_pkg.sv
// Shared types, constants and helpers of the ray and sphere shader pipeline.
package rsh_pkg;

  localparam int MAX_IMAGE_SIDE  = 1024;
  localparam int IDX_W           = 10;
  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = COORD_FRAC_BITS + 5;
  localparam int COLOUR_BITS     = 12;
  localparam int COLOUR_W        = COLOUR_BITS + 1;
  localparam int COLOUR_ONE      = 1 << COLOUR_BITS;
  localparam int RED_K           = COLOUR_ONE / 4;
  localparam int GREEN_K         = (35 * COLOUR_ONE + 50) / 100;
  localparam int REG_W           = 3 * COORD_W;
  localparam int DATA_W          = 64;
  localparam int ADDR_W          = 5;
  localparam int DOT_W           = 2 * COORD_W;
  localparam int FIFO_DEPTH      = 32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [2:0][COORD_W-1:0] vec_t;

  typedef enum logic [1:0] {
    REG_CAM = 2'd0,
    REG_P00 = 2'd1,
    REG_DU  = 2'd2,
    REG_DV  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    vec_t cam;
    vec_t p00;
    vec_t du;
    vec_t dv;
  } cfg_t;

  typedef struct packed {
    vec_t d;
    vec_t oc;
  } ray_t;

  typedef struct packed {
    logic             hit;
    logic [DOT_W-1:0] a;
    coord_t           dy;
  } ht_t;

  typedef struct packed {
    logic                sphere_hit;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
  } pix_t;

  function automatic coord_t sat_coord(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sd1 <<< (COORD_W - 1);
    hi = hi - 34'sd1;
    lo = -hi - 34'sd1;
    if (v > hi) begin
      return coord_t'(hi);
    end else if (v < lo) begin
      return coord_t'(lo);
    end
    return coord_t'(v);
  endfunction

endpackage

// File: rtl/rsh_ifs.sv
// Valid and ready channels for pixel coordinates and shaded colours.
interface rsh_in_if;
  logic                      valid;
  logic                      ready;
  logic [rsh_pkg::IDX_W-1:0] column;
  logic [rsh_pkg::IDX_W-1:0] row;
  modport source (output valid, output column, output row, input ready);
  modport sink (input valid, input column, input row, output ready);
endinterface

interface rsh_out_if;
  logic                         valid;
  logic                         ready;
  logic                         sphere_hit;
  logic [rsh_pkg::COLOUR_W-1:0] red;
  logic [rsh_pkg::COLOUR_W-1:0] green;
  logic [rsh_pkg::COLOUR_W-1:0] blue;
  modport source (output valid, output sphere_hit, output red, output green, output blue,
                  input ready);
  modport sink (input valid, input sphere_hit, input red, input green, input blue,
                output ready);
endinterface

// File: rtl/rsh_ray_gen.sv
// Ray direction and origin offset: two stages of multiply then sum and saturate.
module rsh_ray_gen (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rsh_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  input  logic [rsh_pkg::IDX_W-1:0] col,
  input  logic [rsh_pkg::IDX_W-1:0] row,
  output logic                      out_valid,
  output rsh_pkg::ray_t             ray
);

  localparam logic [rsh_pkg::IDX_W-1:0] IdxMax = rsh_pkg::IDX_W'(rsh_pkg::MAX_IMAGE_SIDE - 1);
  localparam logic signed [33:0] OneC = 34'sd1 <<< rsh_pkg::COORD_FRAC_BITS;

  logic [rsh_pkg::IDX_W-1:0] col_c, row_c;
  logic signed [31:0] pu_nxt [3];
  logic signed [31:0] pv_nxt [3];
  logic signed [31:0] pu_r [3];
  logic signed [31:0] pv_r [3];
  rsh_pkg::vec_t oc_nxt, oc_r, d_nxt;
  logic a_valid_r;
  logic b_valid_r;
  rsh_pkg::ray_t ray_r;

  always_comb begin
    col_c = (col > IdxMax) ? IdxMax : col;
    row_c = (row > IdxMax) ? IdxMax : row;
    for (int k = 0; k < 3; k++) begin
      pu_nxt[k] = 32'($signed(cfg.du[k]) * $signed({1'b0, col_c}));
      pv_nxt[k] = 32'($signed(cfg.dv[k]) * $signed({1'b0, row_c}));
    end
    oc_nxt[0] = rsh_pkg::sat_coord(34'sd0 - 34'($signed(cfg.cam[0])));
    oc_nxt[1] = rsh_pkg::sat_coord(34'sd0 - 34'($signed(cfg.cam[1])));
    oc_nxt[2] = rsh_pkg::sat_coord(-OneC - 34'($signed(cfg.cam[2])));
    for (int k = 0; k < 3; k++) begin
      d_nxt[k] = rsh_pkg::sat_coord(34'($signed(cfg.p00[k])) + 34'(pu_r[k]) + 34'(pv_r[k])
                                    - 34'($signed(cfg.cam[k])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
    for (int k = 0; k < 3; k++) begin
      pu_r[k] <= pu_nxt[k];
      pv_r[k] <= pv_nxt[k];
    end
    oc_r     <= oc_nxt;
    ray_r.d  <= d_nxt;
    ray_r.oc <= oc_r;
  end

  assign out_valid = b_valid_r;
  assign ray       = ray_r;

endmodule

// File: rtl/rsh_hit_test.sv
// Discriminant test: dot products, then the exact 84-bit compare in split partial products.
module rsh_hit_test (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  rsh_pkg::ray_t ray,
  output logic          out_valid,
  output rsh_pkg::ht_t  ht
);

  localparam int DW = rsh_pkg::DOT_W;
  localparam int HW = DW / 2;
  localparam int PW = 2 * DW;
  localparam logic signed [DW+1:0] RadSq = (DW+2)'(1) <<< (2 * rsh_pkg::COORD_FRAC_BITS - 2);

  logic [4:0] v_r;
  logic signed [DW-1:0] dd_r [3];
  logic signed [DW-1:0] do_r [3];
  logic signed [DW-1:0] oo_r [3];
  rsh_pkg::coord_t dy_r [5];
  logic [DW-1:0] a_r [4];
  logic signed [DW+1:0] b_s, c_s, a_s;
  logic [DW-1:0] bm_r, cm_r;
  logic cneg_r [3];
  logic [DW-1:0] bhh_r, bhl_r, bll_r, ahh_r, ahl_r, alh_r, all_r;
  logic [PW-1:0] lhs_r, rhs_r;
  logic hit_r;

  always_comb begin
    a_s = '0;
    b_s = '0;
    c_s = -RadSq;
    for (int k = 0; k < 3; k++) begin
      a_s = a_s + (DW+2)'(dd_r[k]);
      b_s = b_s + (DW+2)'(do_r[k]);
      c_s = c_s + (DW+2)'(oo_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], in_valid};
    end
    for (int k = 0; k < 3; k++) begin
      dd_r[k] <= DW'($signed(ray.d[k]) * $signed(ray.d[k]));
      do_r[k] <= DW'($signed(ray.d[k]) * $signed(ray.oc[k]));
      oo_r[k] <= DW'($signed(ray.oc[k]) * $signed(ray.oc[k]));
    end
    dy_r[0] <= ray.d[1];
    for (int s = 1; s < 5; s++) begin
      dy_r[s] <= dy_r[s-1];
    end
    a_r[0] <= a_s[DW-1:0];
    for (int s = 1; s < 4; s++) begin
      a_r[s] <= a_r[s-1];
    end
    bm_r      <= b_s[DW+1] ? DW'(-b_s) : b_s[DW-1:0];
    cm_r      <= c_s[DW-1:0];
    cneg_r[0] <= c_s[DW+1];
    cneg_r[1] <= cneg_r[0];
    cneg_r[2] <= cneg_r[1];
    bhh_r <= DW'(bm_r[DW-1:HW] * bm_r[DW-1:HW]);
    bhl_r <= DW'(bm_r[DW-1:HW] * bm_r[HW-1:0]);
    bll_r <= DW'(bm_r[HW-1:0] * bm_r[HW-1:0]);
    ahh_r <= DW'(a_r[0][DW-1:HW] * cm_r[DW-1:HW]);
    ahl_r <= DW'(a_r[0][DW-1:HW] * cm_r[HW-1:0]);
    alh_r <= DW'(a_r[0][HW-1:0] * cm_r[DW-1:HW]);
    all_r <= DW'(a_r[0][HW-1:0] * cm_r[HW-1:0]);
    lhs_r <= (PW'(bhh_r) << DW) + (PW'(bhl_r) << (HW + 1)) + PW'(bll_r);
    rhs_r <= (PW'(ahh_r) << DW) + ((PW'(ahl_r) + PW'(alh_r)) << HW) + PW'(all_r);
    hit_r <= cneg_r[2] || (lhs_r >= rhs_r);
  end

  assign out_valid = v_r[4];
  assign ht.hit    = hit_r;
  assign ht.a      = a_r[3];
  assign ht.dy     = dy_r[4];

endmodule

// File: rtl/rsh_sky.sv
// Sky shading: pipelined square root, pipelined long division, then the colour blend.
module rsh_sky (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  rsh_pkg::ht_t  ht,
  output logic          out_valid,
  output rsh_pkg::pix_t pix
);

  localparam int DW      = rsh_pkg::DOT_W;
  localparam int SQ_IT   = DW / 2;
  localparam int PER     = 2;
  localparam int SQ_ST   = (SQ_IT + PER - 1) / PER;
  localparam int QB      = rsh_pkg::COLOUR_BITS + 1;
  localparam int DV_ST   = (QB + PER - 1) / PER;
  localparam int SW      = SQ_IT;
  localparam int RW      = rsh_pkg::COORD_W + rsh_pkg::COLOUR_BITS + 1;
  localparam int CW      = rsh_pkg::COLOUR_W;
  localparam int GW      = CW + 12;
  localparam logic [CW-1:0] One  = CW'(rsh_pkg::COLOUR_ONE);
  localparam logic [CW-1:0] Half = CW'(rsh_pkg::COLOUR_ONE / 2);

  // square root stages
  logic [SQ_ST-1:0] sv_r;
  logic [DW-1:0] sq_v_r [SQ_ST];
  logic [DW-1:0] sq_res_r [SQ_ST];
  logic [SQ_ST-1:0] sq_hit_r;
  logic [SQ_ST-1:0] sq_neg_r;
  logic [rsh_pkg::COORD_W-1:0] sq_ym_r [SQ_ST];

  for (genvar g = 0; g < SQ_ST; g++) begin : g_sq
    logic [DW-1:0] v_nxt, res_nxt, bitv;
    logic [DW-1:0] v_in, res_in;
    logic vin, hin, nin;
    logic [rsh_pkg::COORD_W-1:0] ym_in;
    if (g == 0) begin : g_first
      assign v_in   = ht.a;
      assign res_in = '0;
      assign vin    = in_valid;
      assign hin    = ht.hit;
      assign nin    = ht.dy[rsh_pkg::COORD_W-1];
      assign ym_in  = ht.dy[rsh_pkg::COORD_W-1] ? rsh_pkg::COORD_W'(-ht.dy) : ht.dy;
    end else begin : g_rest
      assign v_in   = sq_v_r[g-1];
      assign res_in = sq_res_r[g-1];
      assign vin    = sv_r[g-1];
      assign hin    = sq_hit_r[g-1];
      assign nin    = sq_neg_r[g-1];
      assign ym_in  = sq_ym_r[g-1];
    end
    always_comb begin
      v_nxt   = v_in;
      res_nxt = res_in;
      bitv    = '0;
      for (int j = 0; j < PER; j++) begin
        if (g * PER + j < SQ_IT) begin
          bitv = DW'(1) << (DW - 2 - 2 * (g * PER + j));
          if (v_nxt >= res_nxt + bitv) begin
            v_nxt   = v_nxt - (res_nxt + bitv);
            res_nxt = (res_nxt >> 1) + bitv;
          end else begin
            res_nxt = res_nxt >> 1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[g] <= 1'b0;
      end else begin
        sv_r[g] <= vin;
      end
      sq_v_r[g]   <= v_nxt;
      sq_res_r[g] <= res_nxt;
      sq_hit_r[g] <= hin;
      sq_neg_r[g] <= nin;
      sq_ym_r[g]  <= ym_in;
    end
  end

  // division stages
  logic [DV_ST-1:0] dv_r;
  logic [RW-1:0] dv_rem_r [DV_ST];
  logic [SW-1:0] dv_s_r [DV_ST];
  logic [QB-1:0] dv_q_r [DV_ST];
  logic [DV_ST-1:0] dv_hit_r;
  logic [DV_ST-1:0] dv_neg_r;

  for (genvar g = 0; g < DV_ST; g++) begin : g_dv
    logic [RW-1:0] rem_in, rem_nxt, sub;
    logic [SW-1:0] s_in;
    logic [QB-1:0] q_in, q_nxt;
    logic vin, hin, nin;
    if (g == 0) begin : g_first
      assign rem_in = RW'(sq_ym_r[SQ_ST-1]) << rsh_pkg::COLOUR_BITS;
      assign s_in   = sq_res_r[SQ_ST-1][SW-1:0];
      assign q_in   = '0;
      assign vin    = sv_r[SQ_ST-1];
      assign hin    = sq_hit_r[SQ_ST-1];
      assign nin    = sq_neg_r[SQ_ST-1];
    end else begin : g_rest
      assign rem_in = dv_rem_r[g-1];
      assign s_in   = dv_s_r[g-1];
      assign q_in   = dv_q_r[g-1];
      assign vin    = dv_r[g-1];
      assign hin    = dv_hit_r[g-1];
      assign nin    = dv_neg_r[g-1];
    end
    always_comb begin
      rem_nxt = rem_in;
      q_nxt   = q_in;
      sub     = '0;
      for (int j = 0; j < PER; j++) begin
        if (g * PER + j < QB) begin
          sub = RW'(s_in) << (QB - 1 - (g * PER + j));
          if (rem_nxt >= sub) begin
            rem_nxt = rem_nxt - sub;
            q_nxt[QB-1-(g*PER+j)] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[g] <= 1'b0;
      end else begin
        dv_r[g] <= vin;
      end
      dv_rem_r[g] <= rem_nxt;
      dv_s_r[g]   <= s_in;
      dv_q_r[g]   <= q_nxt;
      dv_hit_r[g] <= hin;
      dv_neg_r[g] <= nin;
    end
  end

  // blend
  logic [CW-1:0] qc, alpha_nxt, alpha_r;
  logic [GW-1:0] prod_g_r;
  logic bl_v_r, bl_hit_r, fin_v_r;
  rsh_pkg::pix_t pix_r;
  logic [CW:0] red_w, green_w;
  logic [GW-1:0] red_t, green_t;

  always_comb begin
    qc = (dv_q_r[DV_ST-1] > One) ? One : dv_q_r[DV_ST-1];
    if (dv_s_r[DV_ST-1] == '0) begin
      alpha_nxt = Half;
    end else if (dv_neg_r[DV_ST-1]) begin
      alpha_nxt = (One - qc) >> 1;
    end else begin
      alpha_nxt = CW'(({1'b0, One} + {1'b0, qc}) >> 1);
    end
    red_t   = ((GW'(alpha_r) * GW'(rsh_pkg::RED_K)) + GW'(Half)) >> rsh_pkg::COLOUR_BITS;
    green_t = (prod_g_r + GW'(Half)) >> rsh_pkg::COLOUR_BITS;
    red_w   = {1'b0, One} - {1'b0, alpha_r} + (CW+1)'(red_t);
    green_w = {1'b0, One} - {1'b0, alpha_r} + (CW+1)'(green_t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bl_v_r  <= 1'b0;
      fin_v_r <= 1'b0;
    end else begin
      bl_v_r  <= dv_r[DV_ST-1];
      fin_v_r <= bl_v_r;
    end
    alpha_r  <= alpha_nxt;
    prod_g_r <= GW'(alpha_nxt) * GW'(rsh_pkg::GREEN_K);
    bl_hit_r <= dv_hit_r[DV_ST-1];
    pix_r.sphere_hit <= bl_hit_r;
    if (bl_hit_r) begin
      pix_r.red   <= One;
      pix_r.green <= '0;
      pix_r.blue  <= '0;
    end else begin
      pix_r.red   <= red_w[CW-1:0];
      pix_r.green <= green_w[CW-1:0];
      pix_r.blue  <= One;
    end
  end

  assign out_valid = fin_v_r;
  assign pix       = pix_r;

endmodule

// File: rtl/ray_sphere_hit_sky_shader_unit.sv
// Top level: register port, shading pipeline and output queue.
//
// Takes one pixel word (column, row) on in_s and returns one colour word on
// out_s: sphere_hit and red, green, blue with 4096 standing for 1.0.
// The camera centre, first pixel centre and the two pixel steps are set
// over the register port (psel, penable, pwrite, paddr, pwdata, prdata,
// pready), 64-bit registers at byte addresses 0, 8, 16 and 24, three
// signed Q5.16 fields each. Write them only while no pixel is in flight.
// One pixel may be accepted every cycle while in_s.ready is high. The
// pipeline depth is set by the square root (11 stages) and the division
// (7 stages). Results enter a 32-word queue; in_s.ready drops once 32
// words are in flight or queued, so a stalled receiver holds the pipeline
// back without loss. Reset clears the registers to zero and empties the
// pipeline and the queue.
module ray_sphere_hit_sky_shader_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  rsh_in_if.sink                     in_s,
  rsh_out_if.source                  out_s,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rsh_pkg::ADDR_W-1:0] paddr,
  input  logic [rsh_pkg::DATA_W-1:0] pwdata,
  output logic [rsh_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int PW = $clog2(rsh_pkg::FIFO_DEPTH);
  localparam int CNW = PW + 1;

  logic [rsh_pkg::REG_W-1:0] cam_r, p00_r, du_r, dv_r;
  rsh_pkg::reg_idx_t idx;
  rsh_pkg::cfg_t cfg;
  logic wr_en;

  assign pready = 1'b1;
  assign idx    = rsh_pkg::reg_idx_t'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r <= '0;
      p00_r <= '0;
      du_r  <= '0;
      dv_r  <= '0;
    end else if (wr_en) begin
      case (idx)
        rsh_pkg::REG_CAM: cam_r <= pwdata[rsh_pkg::REG_W-1:0];
        rsh_pkg::REG_P00: p00_r <= pwdata[rsh_pkg::REG_W-1:0];
        rsh_pkg::REG_DU:  du_r  <= pwdata[rsh_pkg::REG_W-1:0];
        rsh_pkg::REG_DV:  dv_r  <= pwdata[rsh_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rsh_pkg::REG_CAM: prdata = {1'b0, cam_r};
      rsh_pkg::REG_P00: prdata = {1'b0, p00_r};
      rsh_pkg::REG_DU:  prdata = {1'b0, du_r};
      rsh_pkg::REG_DV:  prdata = {1'b0, dv_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.cam = cam_r;
  assign cfg.p00 = p00_r;
  assign cfg.du  = du_r;
  assign cfg.dv  = dv_r;

  logic in_acc, out_acc;
  logic ray_v, ht_v, pix_v;
  rsh_pkg::ray_t ray;
  rsh_pkg::ht_t ht;
  rsh_pkg::pix_t pix;

  rsh_ray_gen u_ray (
    .clk, .rst_n, .cfg,
    .in_valid (in_acc),
    .col      (in_s.column),
    .row      (in_s.row),
    .out_valid(ray_v),
    .ray
  );

  rsh_hit_test u_hit (
    .clk, .rst_n,
    .in_valid (ray_v),
    .ray,
    .out_valid(ht_v),
    .ht
  );

  rsh_sky u_sky (
    .clk, .rst_n,
    .in_valid (ht_v),
    .ht,
    .out_valid(pix_v),
    .pix
  );

  rsh_pkg::pix_t fifo_r [rsh_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNW-1:0] cnt_r, fill_r;

  assign in_s.ready = (cnt_r < CNW'(rsh_pkg::FIFO_DEPTH));
  assign in_acc     = in_s.valid && in_s.ready;
  assign out_s.valid = (fill_r != '0);
  assign out_acc    = out_s.valid && out_s.ready;
  assign out_s.sphere_hit = fifo_r[rd_ptr_r].sphere_hit;
  assign out_s.red        = fifo_r[rd_ptr_r].red;
  assign out_s.green      = fifo_r[rd_ptr_r].green;
  assign out_s.blue       = fifo_r[rd_ptr_r].blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      fill_r   <= '0;
    end else begin
      if (pix_v) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      cnt_r  <= cnt_r + CNW'(in_acc) - CNW'(out_acc);
      fill_r <= fill_r + CNW'(pix_v) - CNW'(out_acc);
    end
    if (pix_v) begin
      fifo_r[wr_ptr_r] <= pix;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNW'(rsh_pkg::FIFO_DEPTH)) else $error("in-flight count overrun");
  a_fill_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cnt_r) else $error("queue holds more than in flight");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    pix_v |-> fill_r < CNW'(rsh_pkg::FIFO_DEPTH) || out_acc) else $error("queue overwrite");
  a_hit_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && out_s.sphere_hit |->
      out_s.red == rsh_pkg::COLOUR_W'(rsh_pkg::COLOUR_ONE) && out_s.green == '0 &&
      out_s.blue == '0) else $error("hit word not pure red");

endmodule

// File: tb/sv/tb_ray_sphere_hit_sky_shader_unit.sv
// Testbench for the ray and sphere sky shader: predicts each colour word and checks it.
module tb_ray_sphere_hit_sky_shader_unit;
  timeunit 1ns;
  timeprecision 1ps;

  class shade_board;
    rsh_pkg::pix_t expected_words[$];
    int unsigned   mismatches;
    logic [62:0]   cam_r, p00_r, du_r, dv_r;

    function new();
      mismatches = 0;
      cam_r = '0;
      p00_r = '0;
      du_r = '0;
      dv_r = '0;
    endfunction

    function void set_reg(rsh_pkg::reg_idx_t idx, logic [63:0] val);
      case (idx)
        rsh_pkg::REG_CAM: cam_r = val[62:0];
        rsh_pkg::REG_P00: p00_r = val[62:0];
        rsh_pkg::REG_DU:  du_r = val[62:0];
        default: dv_r = val[62:0];
      endcase
    endfunction

    function longint fld(logic [62:0] w, int k);
      logic signed [rsh_pkg::COORD_W-1:0] f;
      f = w[k*rsh_pkg::COORD_W +: rsh_pkg::COORD_W];
      return longint'(f);
    endfunction

    function longint clamp_coord(longint v);
      longint hi;
      hi = (longint'(1) <<< (rsh_pkg::COORD_W - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function rsh_pkg::pix_t shade(logic [9:0] col, logic [9:0] row);
      longint d[3], oc[3], a, b, c, q, s, ym, alpha, one;
      logic signed [127:0] lhs, rhs;
      rsh_pkg::pix_t p;
      one = longint'(rsh_pkg::COLOUR_ONE);
      for (int k = 0; k < 3; k++) begin
        d[k] = clamp_coord(fld(p00_r, k) + longint'(col) * fld(du_r, k)
                           + longint'(row) * fld(dv_r, k) - fld(cam_r, k));
        oc[k] = clamp_coord((k == 2 ? -65536 : 0) - fld(cam_r, k));
      end
      a = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
      b = d[0]*oc[0] + d[1]*oc[1] + d[2]*oc[2];
      c = oc[0]*oc[0] + oc[1]*oc[1] + oc[2]*oc[2] - (longint'(1) <<< 30);
      lhs = 128'(b) * 128'(b);
      rhs = 128'(a) * 128'(c);
      p.sphere_hit = (c < 0) || (lhs >= rhs);
      if (p.sphere_hit) begin
        p.red = rsh_pkg::COLOUR_W'(one);
        p.green = '0;
        p.blue = '0;
      end else begin
        s = longint'(root_floor(64'(a)));
        if (s == 0) begin
          alpha = one / 2;
        end else begin
          ym = d[1] < 0 ? -d[1] : d[1];
          q = (ym <<< rsh_pkg::COLOUR_BITS) / s;
          if (q > one) q = one;
          alpha = d[1] < 0 ? (one - q) >>> 1 : (one + q) >>> 1;
        end
        p.red = rsh_pkg::COLOUR_W'(one - alpha
                + ((alpha * rsh_pkg::RED_K + one / 2) >>> rsh_pkg::COLOUR_BITS));
        p.green = rsh_pkg::COLOUR_W'(one - alpha
                  + ((alpha * rsh_pkg::GREEN_K + one / 2) >>> rsh_pkg::COLOUR_BITS));
        p.blue = rsh_pkg::COLOUR_W'(one);
      end
      return p;
    endfunction

    function void note_pixel(logic [9:0] col, logic [9:0] row);
      expected_words.push_back(shade(col, row));
    endfunction

    function void check_word(rsh_pkg::pix_t got);
      rsh_pkg::pix_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
        return;
      end
      want = expected_words.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word mismatch: hit %0d/%0d red %0d/%0d green %0d/%0d blue %0d/%0d",
                   want.sphere_hit, got.sphere_hit, want.red, got.red,
                   want.green, got.green, want.blue, got.blue);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [rsh_pkg::ADDR_W-1:0] paddr = '0;
  logic [rsh_pkg::DATA_W-1:0] pwdata = '0;
  logic [rsh_pkg::DATA_W-1:0] prdata;
  logic pready;
  rsh_in_if in_ch();
  rsh_out_if out_ch();

  shade_board board = new();
  int sender_idle = 0;
  int receiver_stall = 0;
  int hold_off = 0;
  longint cycles = 0;

  ray_sphere_hit_sky_shader_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_ch.sink), .out_s(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    in_ch.valid = 0;
    in_ch.column = '0;
    in_ch.row = '0;
    out_ch.ready = 0;
  end

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("ray_sphere_hit_sky_shader_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_word({out_ch.sphere_hit, out_ch.red, out_ch.green, out_ch.blue});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_stall);
    end
  end

  task automatic write_reg(rsh_pkg::reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= rsh_pkg::ADDR_W'(8 * int'(idx));
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.set_reg(idx, val);
  endtask

  task automatic send_pixel(logic [9:0] col, logic [9:0] row);
    while ($urandom_range(99) < sender_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.column <= col;
    in_ch.row <= row;
    do @(posedge clk); while (!in_ch.ready);
    board.note_pixel(col, row);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] pack3(int x, int y, int z);
    return {1'b0, rsh_pkg::COORD_W'(z), rsh_pkg::COORD_W'(y), rsh_pkg::COORD_W'(x)};
  endfunction

  function automatic logic [63:0] rand_vec(int span);
    return pack3($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                 $urandom_range(2 * span) - span);
  endfunction

  task automatic camera_setup(int mode);
    case (mode)
      0: begin
        write_reg(rsh_pkg::REG_CAM, pack3(0, 0, 0));
        write_reg(rsh_pkg::REG_P00, pack3(-131072, 65536, -65536));
        write_reg(rsh_pkg::REG_DU, pack3(512, 0, 0));
        write_reg(rsh_pkg::REG_DV, pack3(0, -512, 0));
      end
      1: begin
        write_reg(rsh_pkg::REG_CAM, {1'b1, 63'h7FFF_FFFF_FFFF_FFFF});
        write_reg(rsh_pkg::REG_P00, 64'h8000_0000_0000_0000);
        write_reg(rsh_pkg::REG_DU, {1'b0, {3{1'b0, {20{1'b1}}}}});
        write_reg(rsh_pkg::REG_DV, {1'b0, {3{1'b1, 20'd0}}});
      end
      2: begin
        write_reg(rsh_pkg::REG_CAM, pack3(0, 0, -65536));
        write_reg(rsh_pkg::REG_P00, rand_vec(300000));
        write_reg(rsh_pkg::REG_DU, rand_vec(2000));
        write_reg(rsh_pkg::REG_DV, rand_vec(2000));
      end
      default: begin
        write_reg(rsh_pkg::REG_CAM, rand_vec(200000));
        write_reg(rsh_pkg::REG_P00, rand_vec(400000));
        write_reg(rsh_pkg::REG_DU, rand_vec(1500));
        write_reg(rsh_pkg::REG_DV, rand_vec(1500));
      end
    endcase
  endtask

  initial begin
    int idle_set[4] = '{0, 68, 0, 35};
    int stall_set[4] = '{0, 0, 68, 35};
    repeat (5) @(posedge clk);
    rst_n <= 1;
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    drain();
    camera_setup(0);
    for (int k = 0; k < 12; k++)
      send_pixel(k[0] ? 10'd1023 : 10'd0, k[1] ? 10'h3FF : 10'(k * 85));
    send_pixel(10'd256, 10'd256);
    send_pixel(10'h2AA, 10'h155);
    send_pixel(10'h155, 10'h2AA);
    drain();
    camera_setup(1);
    for (int k = 0; k < 6; k++) send_pixel(10'(k * 200), 10'(1023 - k * 200));
    drain();
    hold_off = 300;
    for (int k = 0; k < 80; k++)
      send_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)));
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      sender_idle = idle_set[ph % 4];
      receiver_stall = stall_set[ph % 4];
      camera_setup(ph == 0 ? 0 : 2 + (ph % 2));
      for (int k = 0; k < 180; k++) begin
        if (ph % 3 == 0)
          send_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)));
        else
          send_pixel(10'($urandom_range(255)), 10'($urandom_range(255)));
      end
      drain();
    end
    if (board.mismatches == 0 && board.expected_words.size() == 0) begin
      $display("ray_sphere_hit_sky_shader_unit regression: pass");
    end else begin
      $display("ray_sphere_hit_sky_shader_unit regression: fail");
    end
    $finish;
  end
endmodule
